@@ hdl/session_id_table_with_expiry_core_macros.svh @@
// Assertion macros for the session id table.
`ifndef SESSION_ID_TABLE_WITH_EXPIRY_CORE_MACROS_SVH
`define SESSION_ID_TABLE_WITH_EXPIRY_CORE_MACROS_SVH
`ifndef SYNTH
`define SIDT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
	else $error("sidt assertion failed");
`define SIDT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("sidt assertion failed");
`else
`define SIDT_ASSERT(lbl, clk, rstn, prop)
`define SIDT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hdl/sidt_pkg.sv @@
// ----------------------------------------------------------------------------
// sidt_pkg
// Shared constants, codes and types of the session id table.
// ----------------------------------------------------------------------------
`default_nettype none
package sidt_pkg;
	localparam int ENTRIES = 64;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int LIFE_W = 16;
	localparam logic [LIFE_W-1:0] LIFE_RESET = 16'd60;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_VALIDATE = 2'd1;
	localparam logic [1:0] OP_EXPIRE = 2'd2;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_DUP = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [31:0] key_high;
		logic [63:0] key_mid;
		logic [63:0] key_low;
		logic        mc;
		logic [31:0] expiry;
	} entry_t;

	typedef struct packed {
		logic load;    // capture the request and restart the scan
		logic rd;      // read the entry at the scan address
		logic finish;  // commit the update and present the result
	} cmd_t;

	typedef struct packed {
		logic addr_last;
	} sts_t;
endpackage
`default_nettype wire

@@ hdl/sidt_ctrl.sv @@
// ----------------------------------------------------------------------------
// sidt_ctrl
// Sequencer that steps the datapath through one scan of the table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "session_id_table_with_expiry_core_macros.svh"
module sidt_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	output sidt_pkg::cmd_t   cmd,
	input  sidt_pkg::sts_t   sts
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.addr_last) begin
					state_d = ST_LAST;
				end
			end
			// The last entry is compared here.
			ST_LAST: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	`SIDT_ASSERT(a_done_to_idle, clk, arst_n, (state_q == ST_DONE) |=> (state_q == ST_IDLE))
	`SIDT_ASSERT(a_scan_end, clk, arst_n, (state_q == ST_SCAN && sts.addr_last) |=> (state_q == ST_LAST))
	`SIDT_ASSERT(a_start_taken, clk, arst_n, (start && !busy) |=> (state_q == ST_SCAN))
endmodule
`default_nettype wire

@@ hdl/sidt_dp.sv @@
// ----------------------------------------------------------------------------
// sidt_dp
// Entry memory, valid bits, scan pipeline and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "session_id_table_with_expiry_core_macros.svh"
module sidt_dp (
	input  wire                          clk,
	input  wire                          arst_n,
	input  sidt_pkg::cmd_t               cmd,
	output sidt_pkg::sts_t               sts,
	input  wire  [1:0]                   operation,
	input  wire  [31:0]                  id_word_high,
	input  wire  [63:0]                  id_word_mid,
	input  wire  [63:0]                  id_word_low,
	input  wire                          is_multicast,
	input  wire  [31:0]                  current_time,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [sidt_pkg::LIFE_W-1:0]  cfg_data,
	output logic                         done,
	output logic [1:0]                   status,
	output logic                         hit,
	output logic [sidt_pkg::CNT_W-1:0]   removed_count
);
	sidt_pkg::entry_t mem [sidt_pkg::ENTRIES];

	logic [sidt_pkg::LIFE_W-1:0] life_q;
	logic [sidt_pkg::ENTRIES-1:0] valid_q;

	logic [1:0]  op_q;
	logic [31:0] key_high_q;
	logic [63:0] key_mid_q;
	logic [63:0] key_low_q;
	logic        mc_q;
	logic [31:0] now_q;

	logic [sidt_pkg::IDX_W-1:0] addr_q;
	sidt_pkg::entry_t           rd_s1;
	logic [sidt_pkg::IDX_W-1:0] idx_s1;
	logic                       cmp_v_s1;

	logic                       match_q;
	logic [sidt_pkg::IDX_W-1:0] match_idx_q;
	logic                       match_mc_q;
	logic                       free_q;
	logic [sidt_pkg::IDX_W-1:0] free_idx_q;
	logic [sidt_pkg::CNT_W-1:0] cnt_q;

	logic [1:0]                 status_q;
	logic                       hit_q;
	logic [sidt_pkg::CNT_W-1:0] removed_q;
	logic                       done_q;

	logic entry_v;
	logic key_eq;
	logic aged;
	logic do_insert;
	logic do_unlink;
	sidt_pkg::entry_t new_entry;

	assign cfg_ready = 1'b1;
	assign sts.addr_last = (addr_q == sidt_pkg::IDX_W'(sidt_pkg::ENTRIES - 1));

	assign entry_v = valid_q[idx_s1];
	assign key_eq = cmp_v_s1 && entry_v && (rd_s1.key_high == key_high_q)
		&& (rd_s1.key_mid == key_mid_q) && (rd_s1.key_low == key_low_q);
	assign aged = cmp_v_s1 && entry_v && (op_q == sidt_pkg::OP_EXPIRE)
		&& (now_q > rd_s1.expiry);

	assign do_insert = cmd.finish && (op_q == sidt_pkg::OP_INSERT) && !match_q && free_q;
	assign do_unlink = cmd.finish && (op_q == sidt_pkg::OP_VALIDATE) && match_q && !match_mc_q;

	always_comb begin
		new_entry.key_high = key_high_q;
		new_entry.key_mid = key_mid_q;
		new_entry.key_low = key_low_q;
		new_entry.mc = mc_q;
		new_entry.expiry = now_q + {16'd0, life_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= sidt_pkg::LIFE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			life_q <= cfg_data;
		end
	end

	// Request capture; payload only.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			key_high_q <= id_word_high;
			key_mid_q <= id_word_mid;
			key_low_q <= id_word_low;
			mc_q <= is_multicast;
			now_q <= current_time;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_s1 <= mem[addr_q];
		end
		if (do_insert) begin
			mem[free_idx_q] <= new_entry;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			cmp_v_s1 <= cmd.rd;
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.rd) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// Scan bookkeeping: first matching slot, lowest free slot, aged count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			match_q <= 1'b0;
			free_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (key_eq && !match_q) begin
				match_q <= 1'b1;
			end
			if (cmp_v_s1 && !entry_v && !free_q) begin
				free_q <= 1'b1;
			end
			if (aged && cnt_q != sidt_pkg::CNT_MAX) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_eq && !match_q) begin
			match_idx_q <= idx_s1;
			match_mc_q <= rd_s1.mc;
		end
		if (cmp_v_s1 && !entry_v && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (aged) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (do_insert) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (do_unlink) begin
				valid_q[match_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			status_q <= sidt_pkg::STAT_DONE;
			hit_q <= 1'b0;
			removed_q <= '0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				status_q <= sidt_pkg::STAT_DONE;
				hit_q <= 1'b0;
				removed_q <= '0;
				case (op_q)
					sidt_pkg::OP_INSERT: begin
						if (match_q) begin
							status_q <= sidt_pkg::STAT_DUP;
						end else if (!free_q) begin
							status_q <= sidt_pkg::STAT_FULL;
						end
					end
					sidt_pkg::OP_VALIDATE: begin
						if (match_q) begin
							hit_q <= 1'b1;
							if (!match_mc_q) begin
								removed_q <= sidt_pkg::CNT_W'(1);
							end
						end else begin
							status_q <= sidt_pkg::STAT_NOT_FOUND;
						end
					end
					sidt_pkg::OP_EXPIRE: begin
						removed_q <= cnt_q;
					end
					default: begin
						status_q <= sidt_pkg::STAT_DONE;
					end
				endcase
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign hit = hit_q;
	assign removed_count = removed_q;

	`SIDT_ASSERT(a_strobe_single, clk, arst_n, done_q |=> !done_q)
	`SIDT_ASSERT(a_hit_status, clk, arst_n, (done_q && hit_q) |-> (status_q == sidt_pkg::STAT_DONE))
	`SIDT_ASSERT(a_no_write_on_dup, clk, arst_n, (do_insert) |-> (!valid_q[free_idx_q]))
endmodule
`default_nettype wire

@@ hdl/session_id_table_with_expiry_core.sv @@
// ----------------------------------------------------------------------------
// session_id_table_with_expiry_core
// Table of 64 session ids with per-entry expiry, searched one entry a cycle.
// ----------------------------------------------------------------------------
// Usage:
// A request (operation, id words, multicast flag, current time) is taken on a
// rising edge with start high and busy low. Insert, validate and expire all
// walk the whole table once through a single read port of the entry memory,
// one entry per cycle, so every request takes the same time.
// The result (status, hit, removed_count) is shown for exactly one cycle with
// done high; that cycle follows the scan of the whole table, and the result
// is taken at the edge that ends it. busy falls in the cycle the result is
// shown, so a new request can be accepted at that edge.
// The lifetime register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high. Write it only while no request is in flight.
// Reset clears every valid bit at once and sets the lifetime to 60; the
// memory contents are not cleared and need no clearing pass.
// The result receiver cannot stall; done must be sampled when it is high.
// ----------------------------------------------------------------------------
`default_nettype none
module session_id_table_with_expiry_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [1:0]                   operation,
	input  wire  [31:0]                  id_word_high,
	input  wire  [63:0]                  id_word_mid,
	input  wire  [63:0]                  id_word_low,
	input  wire                          is_multicast,
	input  wire  [31:0]                  current_time,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [sidt_pkg::LIFE_W-1:0]  cfg_data,
	output logic                         done,
	output logic [1:0]                   status,
	output logic                         hit,
	output logic [sidt_pkg::CNT_W-1:0]   removed_count
);
	sidt_pkg::cmd_t cmd;
	sidt_pkg::sts_t sts;

	sidt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	sidt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.id_word_high  (id_word_high),
		.id_word_mid   (id_word_mid),
		.id_word_low   (id_word_low),
		.is_multicast  (is_multicast),
		.current_time  (current_time),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.done          (done),
		.status        (status),
		.hit           (hit),
		.removed_count (removed_count)
	);
endmodule
`default_nettype wire
